// ----- rtl/core/mse_pkg.sv -----
// Shared types and constants for the MIPS subset executor.
// Holds instruction codes, request classes, queue entry and sequencer state types.
// Depends on nothing.
package mse_pkg;

   // Request modes as they arrive on the request channel.
   localparam logic [1:0] MODE_EXEC    = 2'd0;
   localparam logic [1:0] MODE_WRITE   = 2'd1;
   localparam logic [1:0] MODE_READ    = 2'd2;
   localparam logic [1:0] MODE_RESTART = 2'd3;

   // Primary opcodes.
   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_REGIMM  = 6'd1;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_JAL     = 6'd3;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_ADDI    = 6'd8;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_ANDI    = 6'd12;
   localparam logic [5:0] OP_ORI     = 6'd13;
   localparam logic [5:0] OP_LUI     = 6'd15;
   localparam logic [5:0] OP_LH      = 6'd33;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_LBU     = 6'd36;
   localparam logic [5:0] OP_LHU     = 6'd37;
   localparam logic [5:0] OP_SB      = 6'd40;
   localparam logic [5:0] OP_SH      = 6'd41;
   localparam logic [5:0] OP_SW      = 6'd43;

   // Function codes of the special opcode.
   localparam logic [5:0] FN_SLL  = 6'd0;
   localparam logic [5:0] FN_SRL  = 6'd2;
   localparam logic [5:0] FN_SLLV = 6'd4;
   localparam logic [5:0] FN_SRLV = 6'd6;
   localparam logic [5:0] FN_JR   = 6'd8;
   localparam logic [5:0] FN_JALR = 6'd9;
   localparam logic [5:0] FN_ADD  = 6'd32;
   localparam logic [5:0] FN_ADDU = 6'd33;
   localparam logic [5:0] FN_SUB  = 6'd34;
   localparam logic [5:0] FN_SUBU = 6'd35;
   localparam logic [5:0] FN_AND  = 6'd36;
   localparam logic [5:0] FN_OR   = 6'd37;
   localparam logic [5:0] FN_XOR  = 6'd38;
   localparam logic [5:0] FN_NOR  = 6'd39;

   // Register-immediate branch selectors in the rt field.
   localparam logic [4:0] RT_BLTZ = 5'd0;
   localparam logic [4:0] RT_BGEZ = 5'd1;

   localparam logic [4:0]  LINK_REG   = 5'd31;
   localparam logic [31:0] KSEG_BASE  = 32'h8000_0000;
   localparam logic [31:0] ENTRY_PC_RESET = 32'h8000_0000;

   // Store sizes, coded as byte count minus one.
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd3;

   typedef enum logic [1:0] {
      KIND_EXEC,
      KIND_WRITE,
      KIND_READ,
      KIND_RESTART
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] instr;
      logic [15:0] mem_addr;
      logic [31:0] mem_data;
   } item_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_LOAD
   } bk_state_type;

endpackage

// ----- rtl/core/mse_front.sv -----
// Front end of the MIPS subset executor: accepts and classifies requests.
// Buffers them in a two-entry queue for the back end. Depends on mse_pkg.
module mse_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_mode,
   input  logic [31:0]      req_instr,
   input  logic [15:0]      req_mem_addr,
   input  logic [31:0]      req_mem_data,
   output logic             q_valid,
   output mse_pkg::item_type q_item,
   input  logic             q_pop
);

   mse_pkg::item_type entries_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              push;
   mse_pkg::item_type new_item;

   // Classify the incoming request by its mode.
   always_comb begin
      new_item.instr    = req_instr;
      new_item.mem_addr = req_mem_addr;
      new_item.mem_data = req_mem_data;
      case (req_mode)
         mse_pkg::MODE_EXEC:    new_item.kind = mse_pkg::KIND_EXEC;
         mse_pkg::MODE_WRITE:   new_item.kind = mse_pkg::KIND_WRITE;
         mse_pkg::MODE_READ:    new_item.kind = mse_pkg::KIND_READ;
         default:               new_item.kind = mse_pkg::KIND_RESTART;
      endcase
   end

   // The queue stalls the channel only when both entries hold requests.
   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (q_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

// ----- rtl/core/mse_back.sv -----
// Back end of the MIPS subset executor: register file, data memory lanes,
// program counter and the result register. Depends on mse_pkg.
module mse_back #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  mse_pkg::item_type q_item,
   output logic              q_pop,
   input  logic              csr_valid,
   input  logic [31:0]       csr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [31:0]       rsp_next_pc,
   output logic [31:0]       rsp_read_data,
   output logic              rsp_invalid_opcode
);

   localparam int MAB      = MEM_ADDR_BITS;
   localparam int ROW_BITS = MEM_ADDR_BITS - 2;
   localparam int ROWS     = 1 << ROW_BITS;

   mse_pkg::bk_state_type state_ff, state_in;
   mse_pkg::item_type     cur_ff;

   logic [31:0] entry_pc_ff;
   logic [31:0] pc_ff, pc_in;
   logic        bp_ff, bp_in;
   logic [31:0] bt_ff, bt_in;

   logic [31:0] rf_ff [32];
   logic [31:0] rf_valid_ff;
   logic [31:0] rs_val_ff;
   logic [31:0] rt_val_ff;
   logic        rf_we;

   logic [31:0] lane_q;
   logic [1:0]  rd_lo_ff;
   logic        rd_en;
   logic [MAB-1:0] rd_addr;
   logic        st_en;
   logic [MAB-1:0] st_addr;
   logic [1:0]  st_size;
   logic [31:0] st_data;

   logic        finish;
   logic        out_free;
   logic        rsp_valid_ff;
   logic [31:0] rsp_next_pc_ff;
   logic [31:0] rsp_read_data_ff;
   logic        rsp_invalid_ff;

   // Decoded fields and results of the current instruction.
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd, sa;
   logic [31:0] imm, simm, a, b, btgt, jtgt, ld_word;
   logic [MAB-1:0] ea, cur_maddr;
   logic        dec_we, dec_redirect, dec_bad, dec_load, dec_store;
   logic [4:0]  dec_wi;
   logic [31:0] dec_wv, dec_target, dec_st_data;
   logic [1:0]  dec_st_size;
   logic [7:0]  ld_b0, ld_b1, ld_b2, ld_b3;

   assign op   = cur_ff.instr[31:26];
   assign rs   = cur_ff.instr[25:21];
   assign rt   = cur_ff.instr[20:16];
   assign rd   = cur_ff.instr[15:11];
   assign sa   = cur_ff.instr[10:6];
   assign fn   = cur_ff.instr[5:0];
   assign imm  = {16'd0, cur_ff.instr[15:0]};
   assign simm = {{16{cur_ff.instr[15]}}, cur_ff.instr[15:0]};
   assign a    = rs_val_ff;
   assign b    = rt_val_ff;
   assign btgt = pc_ff + 32'd4 + {simm[29:0], 2'b00};
   assign jtgt = {4'd0, cur_ff.instr[25:0], 2'b00} | mse_pkg::KSEG_BASE;
   assign ea   = MAB'(a + simm);
   assign cur_maddr = MAB'(cur_ff.mem_addr);

   // Big-endian assembly of the bytes returned by the memory lanes.
   assign ld_b0   = lane_q[{rd_lo_ff, 3'd0} +: 8];
   assign ld_b1   = lane_q[{2'(rd_lo_ff + 2'd1), 3'd0} +: 8];
   assign ld_b2   = lane_q[{2'(rd_lo_ff + 2'd2), 3'd0} +: 8];
   assign ld_b3   = lane_q[{2'(rd_lo_ff + 2'd3), 3'd0} +: 8];
   assign ld_word = {ld_b0, ld_b1, ld_b2, ld_b3};

   // Instruction decode and execute.
   always_comb begin
      dec_we       = 1'b0;
      dec_wi       = rd;
      dec_wv       = 32'd0;
      dec_redirect = 1'b0;
      dec_target   = a;
      dec_bad      = 1'b0;
      dec_load     = 1'b0;
      dec_store    = 1'b0;
      dec_st_size  = mse_pkg::SIZE_WORD;
      dec_st_data  = b;
      case (op)
         mse_pkg::OP_SPECIAL: begin
            dec_we = 1'b1;
            case (fn)
               mse_pkg::FN_SLL:  dec_wv = b << sa;
               mse_pkg::FN_SRL:  dec_wv = b >> sa;
               mse_pkg::FN_SLLV: dec_wv = b << a[4:0];
               mse_pkg::FN_SRLV: dec_wv = b >> a[4:0];
               mse_pkg::FN_JR: begin
                  dec_we       = 1'b0;
                  dec_redirect = 1'b1;
               end
               mse_pkg::FN_JALR: begin
                  dec_redirect = 1'b1;
                  dec_wv       = pc_ff + 32'd8;
               end
               mse_pkg::FN_ADD, mse_pkg::FN_ADDU: dec_wv = a + b;
               mse_pkg::FN_SUB, mse_pkg::FN_SUBU: dec_wv = a - b;
               mse_pkg::FN_AND:  dec_wv = a & b;
               mse_pkg::FN_OR:   dec_wv = a | b;
               mse_pkg::FN_XOR:  dec_wv = a ^ b;
               mse_pkg::FN_NOR:  dec_wv = ~(a | b);
               default: begin
                  dec_we  = 1'b0;
                  dec_bad = 1'b1;
               end
            endcase
         end
         mse_pkg::OP_REGIMM: begin
            dec_target = btgt;
            if (rt == mse_pkg::RT_BLTZ) begin
               dec_redirect = a[31];
            end else if (rt == mse_pkg::RT_BGEZ) begin
               dec_redirect = !a[31];
            end else begin
               dec_bad = 1'b1;
            end
         end
         mse_pkg::OP_J: begin
            dec_redirect = 1'b1;
            dec_target   = jtgt;
         end
         mse_pkg::OP_JAL: begin
            dec_redirect = 1'b1;
            dec_target   = jtgt;
            dec_we       = 1'b1;
            dec_wi       = mse_pkg::LINK_REG;
            dec_wv       = pc_ff + 32'd8;
         end
         mse_pkg::OP_BEQ: begin
            dec_redirect = (a == b);
            dec_target   = btgt;
         end
         mse_pkg::OP_BNE: begin
            dec_redirect = (a != b);
            dec_target   = btgt;
         end
         mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
            dec_we = 1'b1;
            dec_wi = rt;
            dec_wv = a + simm;
         end
         mse_pkg::OP_ANDI: begin
            dec_we = 1'b1;
            dec_wi = rt;
            dec_wv = a & imm;
         end
         mse_pkg::OP_ORI: begin
            dec_we = 1'b1;
            dec_wi = rt;
            dec_wv = a | imm;
         end
         mse_pkg::OP_LUI: begin
            dec_we = 1'b1;
            dec_wi = rt;
            dec_wv = {imm[15:0], 16'd0};
         end
         mse_pkg::OP_LH: begin
            dec_load = 1'b1;
            dec_we   = 1'b1;
            dec_wi   = rt;
            dec_wv   = {{16{ld_b0[7]}}, ld_b0, ld_b1};
         end
         mse_pkg::OP_LW: begin
            dec_load = 1'b1;
            dec_we   = 1'b1;
            dec_wi   = rt;
            dec_wv   = ld_word;
         end
         mse_pkg::OP_LBU: begin
            dec_load = 1'b1;
            dec_we   = 1'b1;
            dec_wi   = rt;
            dec_wv   = {24'd0, ld_b0};
         end
         mse_pkg::OP_LHU: begin
            dec_load = 1'b1;
            dec_we   = 1'b1;
            dec_wi   = rt;
            dec_wv   = {16'd0, ld_b0, ld_b1};
         end
         mse_pkg::OP_SB: begin
            dec_store   = 1'b1;
            dec_st_size = mse_pkg::SIZE_BYTE;
            dec_st_data = {b[7:0], 24'd0};
         end
         mse_pkg::OP_SH: begin
            dec_store   = 1'b1;
            dec_st_size = mse_pkg::SIZE_HALF;
            dec_st_data = {b[15:0], 16'd0};
         end
         mse_pkg::OP_SW: begin
            dec_store = 1'b1;
         end
         default: begin
            dec_bad = 1'b1;
         end
      endcase
   end

   // A result can leave when the output register is empty or being taken.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer: fetch operands, execute, and for loads a memory read step.
   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      finish   = 1'b0;
      rf_we    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = cur_maddr;
      st_en    = 1'b0;
      st_addr  = ea;
      st_size  = dec_st_size;
      st_data  = dec_st_data;
      case (state_ff)
         mse_pkg::BK_IDLE: begin
            rd_addr = MAB'(q_item.mem_addr);
            if (q_valid) begin
               q_pop    = 1'b1;
               rd_en    = (q_item.kind == mse_pkg::KIND_READ);
               state_in = mse_pkg::BK_EXEC;
            end
         end
         mse_pkg::BK_EXEC: begin
            if (cur_ff.kind == mse_pkg::KIND_EXEC && dec_load) begin
               rd_en    = 1'b1;
               rd_addr  = ea;
               state_in = mse_pkg::BK_LOAD;
            end else if (out_free) begin
               finish   = 1'b1;
               state_in = mse_pkg::BK_IDLE;
               case (cur_ff.kind)
                  mse_pkg::KIND_EXEC: begin
                     rf_we = dec_we;
                     st_en = dec_store;
                  end
                  mse_pkg::KIND_WRITE: begin
                     st_en   = 1'b1;
                     st_addr = cur_maddr;
                     st_size = mse_pkg::SIZE_WORD;
                     st_data = cur_ff.mem_data;
                  end
                  default: begin
                  end
               endcase
            end
         end
         mse_pkg::BK_LOAD: begin
            if (out_free) begin
               finish   = 1'b1;
               rf_we    = dec_we;
               state_in = mse_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = mse_pkg::BK_IDLE;
         end
      endcase
   end

   // Program counter and delay-slot branch state.
   always_comb begin
      pc_in = pc_ff;
      bp_in = bp_ff;
      bt_in = bt_ff;
      if (finish) begin
         case (cur_ff.kind)
            mse_pkg::KIND_EXEC: begin
               if (bp_ff) begin
                  pc_in = bt_ff;
                  bp_in = 1'b0;
               end else begin
                  pc_in = pc_ff + 32'd4;
                  if (dec_redirect) begin
                     bp_in = 1'b1;
                     bt_in = dec_target;
                  end
               end
            end
            mse_pkg::KIND_RESTART: begin
               pc_in = entry_pc_ff;
               bp_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mse_pkg::BK_IDLE;
         entry_pc_ff  <= mse_pkg::ENTRY_PC_RESET;
         pc_ff        <= mse_pkg::ENTRY_PC_RESET;
         bp_ff        <= 1'b0;
         bt_ff        <= 32'd0;
         rsp_valid_ff <= 1'b0;
         rf_valid_ff  <= 32'd0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         bp_ff        <= bp_in;
         bt_ff        <= bt_in;
         rsp_valid_ff <= finish || (rsp_valid_ff && rsp_stall);
         if (csr_valid) begin
            entry_pc_ff <= csr_data;
         end
         if (rf_we && dec_wi != 5'd0) begin
            rf_valid_ff[dec_wi] <= 1'b1;
         end
      end
   end

   // Payload registers: current request and result.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_item;
      end
      if (finish) begin
         rsp_next_pc_ff   <= pc_in;
         rsp_read_data_ff <= (cur_ff.kind == mse_pkg::KIND_READ) ? ld_word : 32'd0;
         rsp_invalid_ff   <= (cur_ff.kind == mse_pkg::KIND_EXEC) && dec_bad;
      end
   end

   // Register file: two registered read ports, one write port.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rs_val_ff <= rf_valid_ff[q_item.instr[25:21]] ? rf_ff[q_item.instr[25:21]] : 32'd0;
         rt_val_ff <= rf_valid_ff[q_item.instr[20:16]] ? rf_ff[q_item.instr[20:16]] : 32'd0;
      end
      if (rf_we && dec_wi != 5'd0) begin
         rf_ff[dec_wi] <= dec_wv;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_lo_ff <= rd_addr[1:0];
      end
   end

   // Data memory as four byte lanes; byte i of an access uses lane (addr + i) mod 4.
   for (genvar lane = 0; lane < 4; lane++) begin : g_lane
      logic [7:0]          mem_ff [ROWS];
      logic [7:0]          q_ff;
      logic [1:0]          rd_off, wr_off;
      logic [MAB-1:0]      rd_byte, wr_byte;
      logic                lane_we;
      logic [7:0]          lane_wd;

      assign rd_off  = 2'(lane) - rd_addr[1:0];
      assign rd_byte = rd_addr + MAB'(rd_off);
      assign wr_off  = 2'(lane) - st_addr[1:0];
      assign wr_byte = st_addr + MAB'(wr_off);
      assign lane_we = st_en && (wr_off <= st_size);
      assign lane_wd = st_data[{2'd3 - wr_off, 3'd0} +: 8];
      assign lane_q[8*lane +: 8] = q_ff;

      always_ff @(posedge clock) begin
         if (rd_en) begin
            q_ff <= mem_ff[rd_byte[MAB-1:2]];
         end
         if (lane_we) begin
            mem_ff[wr_byte[MAB-1:2]] <= lane_wd;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_pc        = rsp_next_pc_ff;
   assign rsp_read_data      = rsp_read_data_ff;
   assign rsp_invalid_opcode = rsp_invalid_ff;

   // The load step is entered only from the execute step.
   a_load_after_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mse_pkg::BK_LOAD) |->
         ($past(state_ff) == mse_pkg::BK_EXEC || $past(state_ff) == mse_pkg::BK_LOAD))
      else $error("load step entered out of sequence");

   // Register zero is never written.
   a_zero_reg: assert property (@(posedge clock) disable iff (reset)
      !rf_valid_ff[0])
      else $error("register zero marked written");

   // A finished restart leaves no branch pending.
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (finish && cur_ff.kind == mse_pkg::KIND_RESTART) |=> !bp_ff)
      else $error("branch still pending after restart");

   // A result is never produced while the previous one would be overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten");

endmodule

// ----- rtl/core/mips_subset_executor_top.sv -----
// Top level of the MIPS subset executor: front request queue and back end.
// Depends on mse_pkg, mse_front and mse_back.
// Each request passes through the front queue and the back-end sequencer, whose
// operand read and execute steps end with the result in the output register; loads
// (LH, LW, LBU, LHU) take an extra memory read step. The sequencer takes no new
// request until the last one is through. Reset clears registers to zero,
// the program counter and entry_pc to 0x80000000; data memory is not cleared.
module mips_subset_executor_top #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_instr,
   input  logic [15:0] req_mem_addr,
   input  logic [31:0] req_mem_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic [31:0] rsp_read_data,
   output logic        rsp_invalid_opcode,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic              q_valid;
   logic              q_pop;
   mse_pkg::item_type q_item;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   mse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_instr    (req_instr),
      .req_mem_addr (req_mem_addr),
      .req_mem_data (req_mem_data),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop)
   );

   mse_back #(
      .MEM_ADDR_BITS (MEM_ADDR_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop),
      .csr_valid          (csr_valid && csr_ready),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_read_data      (rsp_read_data),
      .rsp_invalid_opcode (rsp_invalid_opcode)
   );

endmodule
